>>> sv/mcs_pkg.sv
package mcs_pkg;

    localparam int SHORT_PERIOD  = 12;
    localparam int LONG_PERIOD   = 26;
    localparam int SIGNAL_PERIOD = 9;
    localparam int PRICE_WIDTH   = 24;

    localparam int GAIN_WIDTH    = 16;
    localparam int MACD_WIDTH    = PRICE_WIDTH + 2;
    // (x - prev) * gain, plus prev << GAIN_WIDTH
    localparam int ACC_WIDTH     = MACD_WIDTH + GAIN_WIDTH + 2;
    localparam int DEC_WIDTH     = 2;
    localparam int CFG_IDX_WIDTH = 2;

    localparam int MAX_SL_PERIOD = (SHORT_PERIOD > LONG_PERIOD) ? SHORT_PERIOD : LONG_PERIOD;
    localparam int MAX_PERIOD    = (MAX_SL_PERIOD > SIGNAL_PERIOD) ? MAX_SL_PERIOD
                                                                   : SIGNAL_PERIOD;
    localparam int SUM_WIDTH     = MACD_WIDTH + $clog2(MAX_PERIOD) + 1;
    localparam int MAG_WIDTH     = SUM_WIDTH - 1;
    localparam int DIV_D_WIDTH   = $clog2(MAX_PERIOD + 1);

    localparam int SIG_SEED_IDX  = LONG_PERIOD + SIGNAL_PERIOD - 2;
    localparam int COUNT_SAT     = (SHORT_PERIOD > SIG_SEED_IDX + 1) ? SHORT_PERIOD
                                                                     : SIG_SEED_IDX + 1;
    localparam int CNT_WIDTH     = $clog2(COUNT_SAT + 1);

    localparam logic [CNT_WIDTH-1:0] CNT_ZERO        = '0;
    localparam logic [CNT_WIDTH-1:0] CNT_SAT         = CNT_WIDTH'(COUNT_SAT);
    localparam logic [CNT_WIDTH-1:0] SHORT_SEED_CNT  = CNT_WIDTH'(SHORT_PERIOD - 1);
    localparam logic [CNT_WIDTH-1:0] LONG_SEED_CNT   = CNT_WIDTH'(LONG_PERIOD - 1);
    localparam logic [CNT_WIDTH-1:0] SIGNAL_SEED_CNT = CNT_WIDTH'(SIG_SEED_IDX);

    localparam logic [DIV_D_WIDTH-1:0] SHORT_DIV  = DIV_D_WIDTH'(SHORT_PERIOD);
    localparam logic [DIV_D_WIDTH-1:0] LONG_DIV   = DIV_D_WIDTH'(LONG_PERIOD);
    localparam logic [DIV_D_WIDTH-1:0] SIGNAL_DIV = DIV_D_WIDTH'(SIGNAL_PERIOD);

    // floor(2^MAG_WIDTH / d): quotient estimate is exact or one short
    localparam logic [MAG_WIDTH-1:0] SHORT_RECIP  =
        MAG_WIDTH'((64'd1 << MAG_WIDTH) / SHORT_PERIOD);
    localparam logic [MAG_WIDTH-1:0] LONG_RECIP   =
        MAG_WIDTH'((64'd1 << MAG_WIDTH) / LONG_PERIOD);
    localparam logic [MAG_WIDTH-1:0] SIGNAL_RECIP =
        MAG_WIDTH'((64'd1 << MAG_WIDTH) / SIGNAL_PERIOD);

    localparam logic [GAIN_WIDTH-1:0]        SHORT_GAIN_RST  = 16'd10082;
    localparam logic [GAIN_WIDTH-1:0]        LONG_GAIN_RST   = 16'd4855;
    localparam logic [GAIN_WIDTH-1:0]        SIGNAL_GAIN_RST = 16'd13107;
    localparam logic signed [GAIN_WIDTH-1:0] MACD_OFFSET_RST = 16'sd250;

    localparam logic [CFG_IDX_WIDTH-1:0] CFG_SHORT_GAIN  = 2'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_LONG_GAIN   = 2'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_SIGNAL_GAIN = 2'd2;
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_MACD_OFFSET = 2'd3;

    typedef enum logic [DEC_WIDTH-1:0] {
        DEC_NONE = 2'd0,
        DEC_BUY  = 2'd1,
        DEC_SELL = 2'd2
    } decision_t;

    typedef enum logic [1:0] {
        PH_SHORT  = 2'd0,
        PH_LONG   = 2'd1,
        PH_SIGNAL = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        MODE_NONE = 2'd0,
        MODE_ACC  = 2'd1,
        MODE_SEED = 2'd2,
        MODE_EMA  = 2'd3
    } mode_t;

    typedef struct packed {
        phase_t phase;
        logic   load_price;
        logic   mul_step;
        logic   fin_step;
        logic   abs_step;
        logic   dmul_step;
        logic   dq_step;
        logic   dfix_step;
        logic   macd_step;
        logic   out_load;
    } cmd_t;

    typedef struct packed {
        mode_t mode;
        logic  out_free;
    } sts_t;

endpackage

>>> sv/mcs_if.sv
interface mcs_in_if;
    import mcs_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [PRICE_WIDTH-1:0] price;

    modport source (output valid, output price, input ready);
    modport sink   (input valid, input price, output ready);
endinterface

interface mcs_out_if;
    import mcs_pkg::*;

    logic                         valid;
    logic                         ready;
    logic [PRICE_WIDTH-1:0]       short_average;
    logic [PRICE_WIDTH-1:0]       long_average;
    logic signed [MACD_WIDTH-1:0] macd_value;
    logic signed [MACD_WIDTH-1:0] signal_value;
    logic [DEC_WIDTH-1:0]         decision;

    modport source (output valid, output short_average, output long_average,
                    output macd_value, output signal_value, output decision,
                    input ready);
    modport sink   (input valid, input short_average, input long_average,
                    input macd_value, input signal_value, input decision,
                    output ready);
endinterface

interface mcs_cfg_if;
    import mcs_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [CFG_IDX_WIDTH-1:0] index;
    logic [GAIN_WIDTH-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

>>> sv/mcs_ctrl.sv
module mcs_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  mcs_pkg::sts_t sts,
    output mcs_pkg::cmd_t cmd
);
    import mcs_pkg::*;

    typedef enum logic [8:0] {
        ST_IDLE = 9'b000000001,
        ST_MUL  = 9'b000000010,
        ST_FIN  = 9'b000000100,
        ST_DABS = 9'b000001000,
        ST_DMUL = 9'b000010000,
        ST_DQ   = 9'b000100000,
        ST_DFIX = 9'b001000000,
        ST_MACD = 9'b010000000,
        ST_DEC  = 9'b100000000
    } state_t;

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;
    state_t adv_state;
    phase_t adv_phase;

    // where to go once the current average is done
    always_comb
    begin
        adv_state = ST_IDLE;
        adv_phase = PH_SHORT;
        case (phase_reg)
            PH_SHORT:
            begin
                adv_state = ST_MUL;
                adv_phase = PH_LONG;
            end
            PH_LONG:
            begin
                adv_state = ST_MACD;
                adv_phase = PH_LONG;
            end
            PH_SIGNAL:
            begin
                adv_state = ST_DEC;
                adv_phase = PH_SIGNAL;
            end
            default:
            begin
                adv_state = ST_IDLE;
                adv_phase = PH_SHORT;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        cmd        = '0;
        cmd.phase  = phase_reg;
        in_ready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_price = 1'b1;
                    state_next     = ST_MUL;
                    phase_next     = PH_SHORT;
                end
            end
            ST_MUL:
            begin
                cmd.mul_step = 1'b1;
                case (sts.mode)
                    MODE_EMA:  state_next = ST_FIN;
                    MODE_SEED: state_next = ST_DABS;
                    default:
                    begin
                        state_next = adv_state;
                        phase_next = adv_phase;
                    end
                endcase
            end
            ST_FIN:
            begin
                cmd.fin_step = 1'b1;
                state_next   = adv_state;
                phase_next   = adv_phase;
            end
            ST_DABS:
            begin
                cmd.abs_step = 1'b1;
                state_next   = ST_DMUL;
            end
            ST_DMUL:
            begin
                cmd.dmul_step = 1'b1;
                state_next    = ST_DQ;
            end
            ST_DQ:
            begin
                cmd.dq_step = 1'b1;
                state_next  = ST_DFIX;
            end
            ST_DFIX:
            begin
                cmd.dfix_step = 1'b1;
                state_next    = adv_state;
                phase_next    = adv_phase;
            end
            ST_MACD:
            begin
                cmd.macd_step = 1'b1;
                state_next    = ST_MUL;
                phase_next    = PH_SIGNAL;
            end
            ST_DEC:
            begin
                // hold until the output register can take the item
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                phase_next = PH_SHORT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_SHORT;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

endmodule

>>> sv/mcs_dp.sv
module mcs_dp (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [mcs_pkg::PRICE_WIDTH-1:0] price,
    input  mcs_pkg::cmd_t                   cmd,
    output mcs_pkg::sts_t                   sts,
    mcs_out_if.source                       result,
    mcs_cfg_if.sink                         cfg
);
    import mcs_pkg::*;

    logic [PRICE_WIDTH-1:0]        price_reg;
    logic [CNT_WIDTH-1:0]          cnt_reg;
    logic signed [SUM_WIDTH-1:0]   short_sum_reg, long_sum_reg, sig_sum_reg;
    logic [PRICE_WIDTH-1:0]        short_ema_reg, long_ema_reg;
    logic signed [MACD_WIDTH-1:0]  sig_line_reg, macd_reg;
    logic                          may_buy_reg, may_sell_reg;
    logic [GAIN_WIDTH-1:0]         short_gain_reg, long_gain_reg, sig_gain_reg;
    logic signed [GAIN_WIDTH-1:0]  offset_reg;
    logic signed [ACC_WIDTH-1:0]   prod_reg;
    logic [MAG_WIDTH-1:0]          mag_reg;
    logic                          neg_reg;
    logic [2*MAG_WIDTH-1:0]        dprod_reg;
    logic [MAG_WIDTH-1:0]          quo_reg, rem_reg;

    logic [PRICE_WIDTH-1:0]        short_avg_reg, long_avg_reg;
    logic signed [MACD_WIDTH-1:0]  macd_out_reg, signal_out_reg;
    logic [DEC_WIDTH-1:0]          decision_reg;
    logic                          out_valid_reg;

    logic signed [MACD_WIDTH-1:0]  x_op, prev_op;
    logic [GAIN_WIDTH-1:0]         gain_op;
    logic signed [SUM_WIDTH-1:0]   sum_op, sum_new;
    logic [CNT_WIDTH-1:0]          start_cnt, seed_cnt;
    logic [DIV_D_WIDTH-1:0]        div_d;
    logic [MAG_WIDTH-1:0]          div_recip;
    mode_t                         mode;

    logic signed [MACD_WIDTH:0]    diff;
    logic signed [GAIN_WIDTH:0]    gain_s;
    logic signed [ACC_WIDTH-1:0]   mul_full, acc, acc_fl, ema_full;
    logic signed [MACD_WIDTH-1:0]  ema_new, div_new, upd_val, macd_calc;
    logic signed [SUM_WIDTH-1:0]   sum_neg;
    logic [MAG_WIDTH-1:0]          dq_quo, dq_rem, q_mag;
    logic [MAG_WIDTH+DIV_D_WIDTH-1:0] qd;
    logic signed [MAG_WIDTH:0]     q_signed;
    decision_t                     dec_code;
    logic                          out_free;

    // operand selection by phase
    always_comb
    begin
        x_op      = $signed({{(MACD_WIDTH-PRICE_WIDTH){1'b0}}, price_reg});
        prev_op   = $signed({{(MACD_WIDTH-PRICE_WIDTH){1'b0}}, short_ema_reg});
        gain_op   = short_gain_reg;
        sum_op    = short_sum_reg;
        start_cnt = CNT_ZERO;
        seed_cnt  = SHORT_SEED_CNT;
        div_d     = SHORT_DIV;
        div_recip = SHORT_RECIP;
        case (cmd.phase)
            PH_SHORT: ;
            PH_LONG:
            begin
                prev_op   = $signed({{(MACD_WIDTH-PRICE_WIDTH){1'b0}}, long_ema_reg});
                gain_op   = long_gain_reg;
                sum_op    = long_sum_reg;
                seed_cnt  = LONG_SEED_CNT;
                div_d     = LONG_DIV;
                div_recip = LONG_RECIP;
            end
            PH_SIGNAL:
            begin
                x_op      = macd_reg;
                prev_op   = sig_line_reg;
                gain_op   = sig_gain_reg;
                sum_op    = sig_sum_reg;
                start_cnt = LONG_SEED_CNT;
                seed_cnt  = SIGNAL_SEED_CNT;
                div_d     = SIGNAL_DIV;
                div_recip = SIGNAL_RECIP;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        if (cnt_reg < start_cnt)
            mode = MODE_NONE;
        else if (cnt_reg < seed_cnt)
            mode = MODE_ACC;
        else if (cnt_reg == seed_cnt)
            mode = MODE_SEED;
        else
            mode = MODE_EMA;
    end

    // ema' = prev + (x - prev) * g / 2^16, truncated toward zero
    assign diff     = (MACD_WIDTH+1)'(x_op) - (MACD_WIDTH+1)'(prev_op);
    assign gain_s   = $signed({1'b0, gain_op});
    assign mul_full = diff * gain_s;
    assign acc      = prod_reg + (ACC_WIDTH'(prev_op) <<< GAIN_WIDTH);
    assign acc_fl   = acc >>> GAIN_WIDTH;
    assign ema_full = acc_fl + ACC_WIDTH'(acc[ACC_WIDTH-1] && (|acc[GAIN_WIDTH-1:0]));
    assign ema_new  = ema_full[MACD_WIDTH-1:0];

    assign sum_new  = sum_op + SUM_WIDTH'(x_op);
    assign sum_neg  = -sum_op;

    // seed mean: magnitude times reciprocal, then one correction step
    assign dq_quo   = dprod_reg[2*MAG_WIDTH-1:MAG_WIDTH];
    assign qd       = dq_quo * div_d;
    assign dq_rem   = mag_reg - qd[MAG_WIDTH-1:0];
    assign q_mag    = quo_reg + MAG_WIDTH'(rem_reg >= MAG_WIDTH'(div_d));
    assign q_signed = neg_reg ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});
    assign div_new  = q_signed[MACD_WIDTH-1:0];

    assign upd_val  = cmd.dfix_step ? div_new : ema_new;

    assign macd_calc = $signed(MACD_WIDTH'(short_ema_reg)) - $signed(MACD_WIDTH'(long_ema_reg))
                       + MACD_WIDTH'(offset_reg);

    always_comb
    begin
        dec_code = DEC_NONE;
        if (cnt_reg >= SIGNAL_SEED_CNT)
        begin
            if (macd_reg > sig_line_reg && may_buy_reg)
                dec_code = DEC_BUY;
            else if (macd_reg < sig_line_reg && may_sell_reg)
                dec_code = DEC_SELL;
        end
    end

    assign out_free     = !out_valid_reg || result.ready;
    assign sts.mode     = mode;
    assign sts.out_free = out_free;

    // working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load_price)
            price_reg <= price;
        if (cmd.mul_step)
            prod_reg <= mul_full;
        if (cmd.abs_step)
        begin
            neg_reg <= sum_op[SUM_WIDTH-1];
            mag_reg <= sum_op[SUM_WIDTH-1] ? sum_neg[MAG_WIDTH-1:0] : sum_op[MAG_WIDTH-1:0];
        end
        if (cmd.dmul_step)
            dprod_reg <= mag_reg * div_recip;
        if (cmd.dq_step)
        begin
            quo_reg <= dq_quo;
            rem_reg <= dq_rem;
        end
    end

    // architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            short_sum_reg <= '0;
            long_sum_reg  <= '0;
            sig_sum_reg   <= '0;
            short_ema_reg <= '0;
            long_ema_reg  <= '0;
            sig_line_reg  <= '0;
            macd_reg      <= '0;
            may_buy_reg   <= 1'b1;
            may_sell_reg  <= 1'b1;
        end
        else
        begin
            if (cmd.mul_step && (mode == MODE_ACC || mode == MODE_SEED))
            begin
                case (cmd.phase)
                    PH_SHORT:  short_sum_reg <= sum_new;
                    PH_LONG:   long_sum_reg  <= sum_new;
                    PH_SIGNAL: sig_sum_reg   <= sum_new;
                    default: ;
                endcase
            end
            if (cmd.fin_step || cmd.dfix_step)
            begin
                case (cmd.phase)
                    PH_SHORT:  short_ema_reg <= upd_val[PRICE_WIDTH-1:0];
                    PH_LONG:   long_ema_reg  <= upd_val[PRICE_WIDTH-1:0];
                    PH_SIGNAL: sig_line_reg  <= upd_val;
                    default: ;
                endcase
            end
            if (cmd.macd_step)
                macd_reg <= (cnt_reg >= LONG_SEED_CNT) ? macd_calc : '0;
            if (cmd.out_load)
            begin
                if (dec_code == DEC_BUY)
                begin
                    may_buy_reg  <= 1'b0;
                    may_sell_reg <= 1'b1;
                end
                else if (dec_code == DEC_SELL)
                begin
                    may_buy_reg  <= 1'b1;
                    may_sell_reg <= 1'b0;
                end
                if (cnt_reg < CNT_SAT)
                    cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    // configuration registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_gain_reg <= SHORT_GAIN_RST;
            long_gain_reg  <= LONG_GAIN_RST;
            sig_gain_reg   <= SIGNAL_GAIN_RST;
            offset_reg     <= MACD_OFFSET_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_SHORT_GAIN:  short_gain_reg <= cfg.data;
                CFG_LONG_GAIN:   long_gain_reg  <= cfg.data;
                CFG_SIGNAL_GAIN: sig_gain_reg   <= cfg.data;
                CFG_MACD_OFFSET: offset_reg     <= $signed(cfg.data);
                default: ;
            endcase
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            short_avg_reg  <= short_ema_reg;
            long_avg_reg   <= long_ema_reg;
            macd_out_reg   <= macd_reg;
            signal_out_reg <= sig_line_reg;
            decision_reg   <= dec_code;
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.short_average = short_avg_reg;
    assign result.long_average  = long_avg_reg;
    assign result.macd_value    = macd_out_reg;
    assign result.signal_value  = signal_out_reg;
    assign result.decision      = decision_reg;

endmodule

>>> sv/macd_crossover_signal_top.sv
// MACD crossover signal generator.
// sample: one closing price per item (valid/ready). result: one item per
// sample carrying the short and long EMAs, MACD, signal line and a
// buy/sell/none decision. cfg: register writes (index, data), always ready;
// write only while the block is idle.
// Sequence: a sample is taken in the idle state; the short, long and signal
// averages then each pass through the shared multiply and finish steps
// of the datapath, one after the other, with a MACD step between. A settled
// sample then reaches the output register from the decision state; no new
// sample is accepted before the block is idle again. Warm-up samples skip
// the finish step; each seed sample instead divides its sum by reciprocal.
// A finished item sits in the output register while the next sample is
// accepted and processed; if the receiver stalls, the block holds the
// following result until the register frees up.
// Reset clears all averages, sums, the sample count and the output valid,
// and restores the default gains and offset.
module macd_crossover_signal_top (
    input logic       clk,
    input logic       rst_n,
    mcs_in_if.sink    sample,
    mcs_out_if.source result,
    mcs_cfg_if.sink   cfg
);
    import mcs_pkg::*;

    cmd_t cmd;
    sts_t sts;
    logic ready;

    assign sample.ready = ready;

    mcs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (sample.valid),
        .in_ready (ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    mcs_dp u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .price  (sample.price),
        .cmd    (cmd),
        .sts    (sts),
        .result (result),
        .cfg    (cfg)
    );

endmodule
